### hw/rtl/ipcm_pkg.sv
// Shared types, constants and palette tables for the iteration palette color map.
// Used by every module under hw/rtl; depends on nothing.
package ipcm_pkg;

    localparam int PALETTE_ENTRIES = 6;
    localparam int FRACTION_BITS   = 8;

    localparam int COUNT_W     = 16;
    localparam int DIV_W       = 16;
    localparam int COLOR_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int NUM_PALETTES = 4;
    localparam int TABLE_SIZE  = 6;

    localparam logic [DIV_W-1:0] ITER_LIMIT_RESET = 16'd100;

    // Register index codes
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_SELECT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ITER_LIMIT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_SHIFT    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLACK_AT_ZERO  = 2'd3;

    typedef struct packed {
        logic [1:0]         palette_select;
        logic [DIV_W-1:0]   iter_limit;
        logic [COUNT_W-1:0] color_shift;
        logic               black_at_zero;
    } ipcm_cfg_t;

    // neon, primary, rainbow, fire
    localparam logic [COLOR_W-1:0] PALETTE_TABLE [NUM_PALETTES][TABLE_SIZE] = '{
        '{24'h000000, 24'h00FF00, 24'h00FFFF, 24'hFF00FF, 24'hFF1493, 24'hFF4500},
        '{24'h0000FF, 24'hFF0000, 24'hFF00FF, 24'h00FF00, 24'h0000FF, 24'hFFFF00},
        '{24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFFA500, 24'hFF0000},
        '{24'h330000, 24'h661400, 24'hCC3300, 24'hFF6600, 24'hFFCC00, 24'hFFFF99}
    };

    // Entries past the end of a built-in palette read as black.
    function automatic logic [COLOR_W-1:0] palette_color(input logic [1:0] sel,
                                                         input logic [3:0] idx);
        logic [COLOR_W-1:0] color;
        color = '0;
        if (idx < 4'(TABLE_SIZE)) begin
            color = PALETTE_TABLE[sel][idx[2:0]];
        end
        return color;
    endfunction

endpackage

### hw/rtl/iteration_palette_color_map.sv
// Top level of the iteration palette color map: config registers, scaling stage,
// divider pipeline and blend stages. Depends on ipcm_pkg, ipcm_div_stage, ipcm_blend.
//
// Maps one 16-bit escape iteration count per beat to a 24-bit RGB color
// (red 23:16, green 15:8, blue 7:0). The count plus color_shift is scaled by
// the palette size and divided by the iteration limit register (zero is taken
// as one); the integer
// quotient modulo the palette size picks a color, the next entry wraps, and the
// FRACTION_BITS-bit fraction blends the two per channel, rounding toward the
// lower value. The block takes one beat per clock unless a stall on m_tready
// holds it, and holds one item in every stage. The stages are one scaling stage,
// one stage per quotient bit of the restoring divider, then palette lookup,
// multiply and finish stages. A stall on m_tready fills empty stages first and
// only then drops s_tready. Write the configuration port only while no beats
// are in flight.
module iteration_palette_color_map #(
    parameter int PALETTE_ENTRIES = ipcm_pkg::PALETTE_ENTRIES,
    parameter int FRACTION_BITS   = ipcm_pkg::FRACTION_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_wr_en,
    input  logic [ipcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ipcm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ipcm_pkg::COUNT_W-1:0]     s_tdata,   // [15:0] iteration
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ipcm_pkg::COLOR_W-1:0]     m_tdata    // [23:0] rgb_color
);

    localparam int DW       = ipcm_pkg::DIV_W;
    localparam int NUM_W    = ipcm_pkg::COUNT_W + 1;
    localparam int IDX_W    = $clog2(PALETTE_ENTRIES);
    localparam int SCALED_W = NUM_W + $clog2(PALETTE_ENTRIES);
    localparam int Q_W      = SCALED_W + FRACTION_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    ipcm_pkg::ipcm_cfg_t cfg_reg;
    logic [DW-1:0]       divisor;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.palette_select <= '0;
            cfg_reg.iter_limit     <= ipcm_pkg::ITER_LIMIT_RESET;
            cfg_reg.color_shift    <= '0;
            cfg_reg.black_at_zero  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ipcm_pkg::REG_PALETTE_SELECT: cfg_reg.palette_select <= cfg_wdata[1:0];
                ipcm_pkg::REG_ITER_LIMIT:     cfg_reg.iter_limit     <= cfg_wdata;
                ipcm_pkg::REG_COLOR_SHIFT:    cfg_reg.color_shift    <= cfg_wdata;
                ipcm_pkg::REG_BLACK_AT_ZERO:  cfg_reg.black_at_zero  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // A zero divisor behaves as one.
    assign divisor = (cfg_reg.iter_limit == '0) ? DW'(1) : cfg_reg.iter_limit;

    // ------------------------------------------------------------------
    // Divider pipeline links: index 0 is the scaling stage output,
    // index k the output of quotient step k.
    // ------------------------------------------------------------------
    logic [Q_W-1:0]           dvd   [Q_W+1];
    logic [DW-1:0]            rem   [Q_W+1];
    logic [IDX_W-1:0]         modv  [Q_W+1];
    logic [FRACTION_BITS-1:0] frac  [Q_W+1];
    logic                     blk   [Q_W+1];
    logic                     vld   [Q_W+1];
    logic                     rdy   [Q_W+1];

    // ------------------------------------------------------------------
    // Scaling stage: add the shift, multiply by the palette size
    // ------------------------------------------------------------------
    logic                scale_vld_reg;
    logic [SCALED_W-1:0] scaled_reg, scaled_next;
    logic                black_reg, black_next;
    logic [NUM_W-1:0]    num;
    logic                scale_ready;

    assign scale_ready = !scale_vld_reg || rdy[0];
    assign s_tready    = scale_ready;

    always_comb begin
        num         = {1'b0, cfg_reg.color_shift} + {1'b0, s_tdata};
        scaled_next = SCALED_W'(num) * SCALED_W'(PALETTE_ENTRIES);
        black_next  = cfg_reg.black_at_zero && (s_tdata == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_vld_reg <= 1'b0;
        end else if (scale_ready) begin
            scale_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (scale_ready && s_tvalid) begin
            scaled_reg <= scaled_next;
            black_reg  <= black_next;
        end
    end

    // Dividend is the scaled value with the fraction bits appended as zeros,
    // so one quotient carries both the palette position and the blend weight.
    assign vld[0]  = scale_vld_reg;
    assign dvd[0]  = {scaled_reg, {FRACTION_BITS{1'b0}}};
    assign rem[0]  = '0;
    assign modv[0] = '0;
    assign frac[0] = '0;
    assign blk[0]  = black_reg;

    genvar k;
    generate
        for (k = 1; k <= Q_W; k++) begin : g_div
            ipcm_div_stage #(
                .Q_W     (Q_W),
                .IDX_W   (IDX_W),
                .FB      (FRACTION_BITS),
                .PE      (PALETTE_ENTRIES),
                .IS_FRAC (k > SCALED_W)
            ) u_step (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .divisor   (divisor),
                .in_valid  (vld[k-1]),
                .in_ready  (rdy[k-1]),
                .in_dvd    (dvd[k-1]),
                .in_rem    (rem[k-1]),
                .in_mod    (modv[k-1]),
                .in_frac   (frac[k-1]),
                .in_black  (blk[k-1]),
                .out_valid (vld[k]),
                .out_ready (rdy[k]),
                .out_dvd   (dvd[k]),
                .out_rem   (rem[k]),
                .out_mod   (modv[k]),
                .out_frac  (frac[k]),
                .out_black (blk[k])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Palette lookup and blend; its last stage is the output register
    // ------------------------------------------------------------------
    ipcm_blend #(
        .IDX_W (IDX_W),
        .FB    (FRACTION_BITS),
        .PE    (PALETTE_ENTRIES)
    ) u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (vld[Q_W]),
        .in_ready  (rdy[Q_W]),
        .in_mod    (modv[Q_W]),
        .in_frac   (frac[Q_W]),
        .in_black  (blk[Q_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_color (m_tdata)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An empty or draining output stage must open the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled while the output stage can advance");

    // After the last quotient step the remainder stays below the divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld[Q_W] |-> (rem[Q_W] < divisor))
        else $error("divider remainder not reduced");

    // The palette index stays within the palette.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld[Q_W] |-> ({1'b0, modv[Q_W]} < (IDX_W+1)'(PALETTE_ENTRIES)))
        else $error("palette index out of range");

endmodule

### hw/rtl/ipcm_div_stage.sv
// One restoring-division step with its own pipeline register and handshake.
// Depends on ipcm_pkg for widths.
module ipcm_div_stage #(
    parameter int Q_W     = 28,
    parameter int IDX_W   = 3,
    parameter int FB      = 8,
    parameter int PE      = 6,
    parameter bit IS_FRAC = 1'b0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [ipcm_pkg::DIV_W-1:0] divisor,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [Q_W-1:0]            in_dvd,
    input  logic [ipcm_pkg::DIV_W-1:0] in_rem,
    input  logic [IDX_W-1:0]          in_mod,
    input  logic [FB-1:0]             in_frac,
    input  logic                      in_black,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [Q_W-1:0]            out_dvd,
    output logic [ipcm_pkg::DIV_W-1:0] out_rem,
    output logic [IDX_W-1:0]          out_mod,
    output logic [FB-1:0]             out_frac,
    output logic                      out_black
);

    localparam int RW = ipcm_pkg::DIV_W;

    logic              valid_reg;
    logic [Q_W-1:0]    dvd_reg, dvd_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [IDX_W-1:0]  mod_reg, mod_next;
    logic [FB-1:0]     frac_reg, frac_next;
    logic              black_reg;

    logic [RW:0]       trial;
    logic [RW:0]       diff;
    logic              ge;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        trial    = {in_rem, in_dvd[Q_W-1]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
        dvd_next = {in_dvd[Q_W-2:0], 1'b0};
    end

    generate
        if (IS_FRAC) begin : g_frac
            // Fraction bits shift in; the palette index is already final.
            assign frac_next = {in_frac[FB-2:0], ge};
            assign mod_next  = in_mod;
        end else begin : g_whole
            // Keep the integer quotient reduced modulo the palette size.
            logic [IDX_W:0] mx;
            logic [IDX_W:0] mx_sub;
            assign mx        = {in_mod, ge};
            assign mx_sub    = mx - (IDX_W+1)'(PE);
            assign mod_next  = (mx >= (IDX_W+1)'(PE)) ? mx_sub[IDX_W-1:0] : mx[IDX_W-1:0];
            assign frac_next = in_frac;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            dvd_reg   <= dvd_next;
            rem_reg   <= rem_next;
            mod_reg   <= mod_next;
            frac_reg  <= frac_next;
            black_reg <= in_black;
        end
    end

    assign out_valid = valid_reg;
    assign out_dvd   = dvd_reg;
    assign out_rem   = rem_reg;
    assign out_mod   = mod_reg;
    assign out_frac  = frac_reg;
    assign out_black = black_reg;

endmodule

### hw/rtl/ipcm_blend.sv
// Palette lookup and per-channel linear blend: lookup, multiply and finish stages.
// Depends on ipcm_pkg for the palette tables and the configuration type.
module ipcm_blend #(
    parameter int IDX_W = 3,
    parameter int FB    = 8,
    parameter int PE    = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ipcm_pkg::ipcm_cfg_t         cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [IDX_W-1:0]            in_mod,
    input  logic [FB-1:0]               in_frac,
    input  logic                        in_black,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ipcm_pkg::COLOR_W-1:0] out_color
);

    localparam int CW = ipcm_pkg::CHAN_W;
    localparam int PW = FB + CW;
    localparam int NCH = 3;

    // Lookup stage
    logic                         v1_reg;
    logic [ipcm_pkg::COLOR_W-1:0] ca_reg, ca_next;
    logic [ipcm_pkg::COLOR_W-1:0] cb_reg, cb_next;
    logic [FB-1:0]                t1_reg;
    logic                         blk1_reg;
    logic [IDX_W-1:0]             ib;

    // Multiply stage
    logic                         v2_reg;
    logic [PW-1:0]                prod_reg [NCH];
    logic [PW-1:0]                prod_next [NCH];
    logic                         up_reg [NCH];
    logic                         up_next [NCH];
    logic [CW-1:0]                a_reg [NCH];
    logic                         blk2_reg;

    // Finish stage
    logic                         v3_reg;
    logic [ipcm_pkg::COLOR_W-1:0] color_reg, color_next;

    logic r1, r2, r3;

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_comb begin
        ib      = (in_mod == IDX_W'(PE - 1)) ? '0 : in_mod + IDX_W'(1);
        ca_next = ipcm_pkg::palette_color(cfg.palette_select, 4'(in_mod));
        cb_next = ipcm_pkg::palette_color(cfg.palette_select, 4'(ib));
    end

    genvar ch;
    generate
        for (ch = 0; ch < NCH; ch++) begin : g_chan
            logic [CW-1:0] a, b, d;
            logic [PW-1:0] p_lo;
            logic [PW:0]   p_up;
            logic [CW-1:0] step_dn;
            logic [CW-1:0] step_up;

            assign a             = ca_reg[ch*CW +: CW];
            assign b             = cb_reg[ch*CW +: CW];
            assign up_next[ch]   = (b >= a);
            assign d             = up_next[ch] ? (b - a) : (a - b);
            assign prod_next[ch] = PW'(t1_reg) * PW'(d);

            // Downward blend rounds the magnitude up so the result floors.
            assign p_lo    = prod_reg[ch];
            assign p_up    = {1'b0, p_lo} + (PW+1)'((1 << FB) - 1);
            assign step_up = p_lo[PW-1:FB];
            assign step_dn = p_up[PW-1:FB];
            assign color_next[ch*CW +: CW] = blk2_reg ? '0 :
                (up_reg[ch] ? (a_reg[ch] + step_up) : (a_reg[ch] - step_dn));
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= in_valid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
            if (r3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            ca_reg   <= ca_next;
            cb_reg   <= cb_next;
            t1_reg   <= in_frac;
            blk1_reg <= in_black;
        end
        if (r2 && v1_reg) begin
            for (int i = 0; i < NCH; i++) begin
                prod_reg[i] <= prod_next[i];
                up_reg[i]   <= up_next[i];
                a_reg[i]    <= ca_reg[i*CW +: CW];
            end
            blk2_reg <= blk1_reg;
        end
        if (r3 && v2_reg) begin
            color_reg <= color_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_color = color_reg;

endmodule
